FILE: hw/rtl/stpbr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// stpbr_pkg
// Shared types and constants of the scope trace pixel byte renderer.
// ---------------------------------------------------------------------------
package stpbr_pkg;

   localparam int SAMPLE_DEPTH = 128;
   localparam int ADDR_W       = $clog2(SAMPLE_DEPTH);
   localparam int SAMPLE_W     = 8;
   localparam int PAGE_W       = 3;
   localparam int COLUMN_W     = 8;
   localparam int PIXEL_W      = 8;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 8;

   // Request opcodes.
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_RENDER = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_MARKER_COLUMN = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CH1_OFFSET    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CH2_OFFSET    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CURSOR_A      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CURSOR_B      = 3'd4;

   // Highest column that returns a nonzero byte.
   localparam logic [COLUMN_W-1:0] COLUMN_LAST = 8'd130;

   typedef struct packed {
      logic [7:0] marker_column;
      logic [7:0] ch1_offset;
      logic [7:0] ch2_offset;
      logic [7:0] cursor_a;
      logic [7:0] cursor_b;
   } cfg_type;

endpackage
`default_nettype wire

FILE: hw/rtl/stpbr_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// stpbr_ram
// Generic RAM with one write port and two registered read ports.
// ---------------------------------------------------------------------------
module stpbr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_a,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule
`default_nettype wire

FILE: hw/rtl/stpbr_csr.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// stpbr_csr
// Configuration register file: marker column, channel offsets and cursors.
// ---------------------------------------------------------------------------
module stpbr_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write_enable,
   input  wire logic [stpbr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [stpbr_pkg::CSR_DATA_W-1:0]  csr_write_data,
   output stpbr_pkg::cfg_type                     cfg
);
   import stpbr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_MARKER_COLUMN: cfg_in.marker_column = csr_write_data;
            CSR_CH1_OFFSET:    cfg_in.ch1_offset    = csr_write_data;
            CSR_CH2_OFFSET:    cfg_in.ch2_offset    = csr_write_data;
            CSR_CURSOR_A:      cfg_in.cursor_a      = csr_write_data;
            CSR_CURSOR_B:      cfg_in.cursor_b      = csr_write_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.marker_column <= 8'd62;
         cfg_ff.ch1_offset    <= 8'd128;
         cfg_ff.ch2_offset    <= 8'd255;
         cfg_ff.cursor_a      <= 8'd0;
         cfg_ff.cursor_b      <= 8'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/stpbr_render.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// stpbr_render
// Builds one vertical pixel byte from two adjacent sample pairs and the
// configuration, and holds it in the result register.
// ---------------------------------------------------------------------------
module stpbr_render (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             render_valid,
   input  wire logic [stpbr_pkg::PAGE_W-1:0]     page,
   input  wire logic [stpbr_pkg::COLUMN_W-1:0]   column,
   input  wire logic [2*stpbr_pkg::SAMPLE_W-1:0] word_cur,
   input  wire logic [2*stpbr_pkg::SAMPLE_W-1:0] word_next,
   input  wire stpbr_pkg::cfg_type               cfg,
   output logic                                  rsp_valid,
   output logic      [stpbr_pkg::PIXEL_W-1:0]    rsp_pixel_byte
);
   import stpbr_pkg::*;

   localparam logic [7:0] TRACE_LAST   = 8'd125;
   localparam logic [7:0] MARKER_FIRST = 8'd127;
   localparam logic [7:0] MARKER_WIDE  = 8'd128;
   localparam logic [7:0] CENTER_TICK  = 8'd64;
   localparam logic [7:0] CH2_HIDDEN   = 8'd255;
   localparam logic [4:0] PAGE_BIAS    = 5'd12;
   localparam logic [4:0] PAGE_TOP     = 5'd12;
   localparam logic [4:0] PAGE_MID     = 5'd15;
   localparam logic [7:0] BITS_LINE    = 8'h88;
   localparam logic [7:0] BITS_TOP     = 8'h80;
   localparam logic [7:0] BITS_MARKER  = 8'h0F;
   localparam logic [7:0] BITS_SIDE    = 8'h04;

   // One bit for a row when that row lies in the band of eight rows at base.
   function automatic logic [7:0] row_bit(input logic [7:0] row, input logic [7:0] base);
      logic [7:0] v;
      v = 8'd0;
      if (row[7:3] == base[7:3]) begin
         v[row[2:0]] = 1'b1;
      end
      return v;
   endfunction

   // Connected trace: the current row plus the span up to the next sample.
   function automatic logic [7:0] trace_bits(input logic [7:0] a, input logic [7:0] b,
                                             input logic [7:0] base);
      logic [7:0] lo;
      logic [7:0] hi;
      logic [7:0] r;
      logic [7:0] v;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      v  = 8'd0;
      for (int n = 0; n < 8; n++) begin
         r = {base[7:3], 3'(n)};
         if (r == a || (lo <= r && r < hi)) begin
            v[n] = 1'b1;
         end
      end
      return v;
   endfunction

   logic [4:0] pg;
   logic [7:0] base;
   logic [7:0] tick;
   logic       ch2_shown;
   logic       wide;
   logic [7:0] r1;
   logic [7:0] r2;
   logic [7:0] own2;
   logic [7:0] pixel_in;
   logic       rsp_valid_ff;
   logic [7:0] rsp_pixel_byte_ff;

   always_comb begin
      pg        = {2'b00, page} + PAGE_BIAS;
      base      = {pg, 3'b000};
      tick      = column + 8'd2;
      ch2_shown = (cfg.ch2_offset != CH2_HIDDEN);
      wide      = (column == MARKER_WIDE);
      r1        = ~cfg.ch1_offset;
      r2        = ~cfg.ch2_offset;
      own2      = row_bit(r2, base);
      pixel_in  = 8'd0;
      if (column <= TRACE_LAST) begin
         // Samples are drawn inverted onto rows: row = 255 - sample.
         pixel_in = trace_bits(~word_cur[7:0], ~word_next[7:0], base);
         if (ch2_shown) begin
            pixel_in |= trace_bits(~word_cur[15:8], ~word_next[15:8], base);
         end
         if (tick[3:0] == 4'd0 && pg[0]) begin
            pixel_in |= BITS_TOP;
         end
         if (tick[1:0] == 2'd0 && pg == PAGE_MID) begin
            pixel_in |= BITS_TOP;
         end
         if (tick == CENTER_TICK) begin
            pixel_in |= BITS_LINE;
         end
         if (pg == PAGE_TOP) begin
            if (tick == cfg.marker_column) begin
               pixel_in |= BITS_MARKER;
            end
            if ({1'b0, tick} == {1'b0, cfg.marker_column} + 9'd1 ||
                {1'b0, tick} + 9'd1 == {1'b0, cfg.marker_column}) begin
               pixel_in |= BITS_SIDE;
            end
         end
         if (tick == cfg.cursor_a) begin
            pixel_in |= BITS_LINE;
         end
         if (tick == cfg.cursor_b) begin
            pixel_in |= BITS_LINE;
         end
      end else if (column >= MARKER_FIRST && column <= COLUMN_LAST) begin
         pixel_in = row_bit(r1, base);
         if (wide) begin
            pixel_in |= row_bit(r1 + 8'd1, base) | row_bit(r1 - 8'd1, base);
         end
         if (ch2_shown) begin
            // Channel 2's own row on this page overrides channel 1's marker.
            if (own2 != 8'd0) begin
               pixel_in = own2;
            end
            if (wide) begin
               pixel_in |= row_bit(r2 + 8'd1, base) | row_bit(r2 - 8'd1, base);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= render_valid;
      end
      rsp_pixel_byte_ff <= pixel_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_byte = rsp_pixel_byte_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/scope_trace_pixel_byte_renderer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// scope_trace_pixel_byte_renderer_unit
// Two-channel scope sample store that renders vertical LCD pixel bytes.
// ---------------------------------------------------------------------------
// A request transaction is taken at a clock edge with start high and busy
// low. A load (opcode 0) writes one sample pair into the 128-entry store and
// returns nothing. A render (opcode 1) returns one pixel byte for a page and
// column. busy is low except while reset is high, so a transaction can be
// started in every cycle: one item per cycle sustained.
// The store is one RAM with two registered read ports; columns c and c+1
// are read at the edge that accepts a render, so a load is visible to any
// render accepted at a later edge. The byte is built in the next cycle and
// registered behind render_ff and the RAM read registers: rsp_valid pulses
// for one cycle. The receiver cannot stall, so results are not held.
// Configuration registers are written through csr_write_enable at any edge
// and should change only while no render is in flight.
// Reset clears the pipeline and loads the register defaults; the sample
// store is not cleared and a render must only read written entries.
// ---------------------------------------------------------------------------
module scope_trace_pixel_byte_renderer_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic                              req_opcode,
   input  wire logic [stpbr_pkg::ADDR_W-1:0]      req_sample_index,
   input  wire logic [stpbr_pkg::SAMPLE_W-1:0]    req_ch1_sample,
   input  wire logic [stpbr_pkg::SAMPLE_W-1:0]    req_ch2_sample,
   input  wire logic [stpbr_pkg::PAGE_W-1:0]      req_page,
   input  wire logic [stpbr_pkg::COLUMN_W-1:0]    req_column,
   output logic                                   rsp_valid,
   output logic      [stpbr_pkg::PIXEL_W-1:0]     rsp_pixel_byte,
   input  wire logic                              csr_write_enable,
   input  wire logic [stpbr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [stpbr_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import stpbr_pkg::*;

   logic                  accept;
   logic                  load_en;
   logic [ADDR_W-1:0]     addr_cur;
   logic [ADDR_W-1:0]     addr_next;
   logic [2*SAMPLE_W-1:0] word_cur;
   logic [2*SAMPLE_W-1:0] word_next;
   logic                  render_ff;
   logic [PAGE_W-1:0]     page_ff;
   logic [COLUMN_W-1:0]   column_ff;
   cfg_type               cfg;

   assign busy      = reset;
   assign accept    = start && !busy;
   assign load_en   = accept && (req_opcode == OP_LOAD);
   assign addr_cur  = req_column[ADDR_W-1:0];
   assign addr_next = req_column[ADDR_W-1:0] + ADDR_W'(1);

   stpbr_ram #(
      .WIDTH (2 * SAMPLE_W),
      .DEPTH (SAMPLE_DEPTH)
   ) u_store (
      .clock     (clock),
      .wr_en     (load_en),
      .wr_addr   (req_sample_index),
      .wr_data   ({req_ch2_sample, req_ch1_sample}),
      .rd_addr_a (addr_cur),
      .rd_addr_b (addr_next),
      .rd_data_a (word_cur),
      .rd_data_b (word_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         render_ff <= 1'b0;
      end else begin
         render_ff <= accept && (req_opcode == OP_RENDER);
      end
      page_ff   <= req_page;
      column_ff <= req_column;
   end

   stpbr_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   stpbr_render u_render (
      .clock          (clock),
      .reset          (reset),
      .render_valid   (render_ff),
      .page           (page_ff),
      .column         (column_ff),
      .word_cur       (word_cur),
      .word_next      (word_next),
      .cfg            (cfg),
      .rsp_valid      (rsp_valid),
      .rsp_pixel_byte (rsp_pixel_byte)
   );

endmodule
`default_nettype wire

FILE: hw/rtl/stpbr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// stpbr_checker
// Port-level checks of result timing for the pixel byte renderer.
// ---------------------------------------------------------------------------
module stpbr_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            start,
   input wire logic                            busy,
   input wire logic                            req_opcode,
   input wire logic [stpbr_pkg::COLUMN_W-1:0]  req_column,
   input wire logic                            rsp_valid,
   input wire logic [stpbr_pkg::PIXEL_W-1:0]   rsp_pixel_byte
);
   import stpbr_pkg::*;

   logic taken;

   assign taken = start && !busy;

   // Every render transaction yields a result from the result register.
   a_render_result: assert property (@(posedge clock) disable iff (reset)
      (taken && req_opcode == OP_RENDER) |=> ##1 rsp_valid)
      else $error("render transaction without result");

   // A load transaction never yields a result.
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (taken && req_opcode == OP_LOAD) |=> ##1 !rsp_valid)
      else $error("result after load transaction");

   // No result appears without a transaction taken before it.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !taken |=> ##1 !rsp_valid)
      else $error("result without transaction");

   // Columns past the marker columns render as blank.
   a_blank_column: assert property (@(posedge clock) disable iff (reset)
      (taken && req_opcode == OP_RENDER && req_column > COLUMN_LAST)
         |=> ##1 (rsp_pixel_byte == 8'd0))
      else $error("nonzero byte for out-of-range column");

   // Reset leaves no result in flight.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result right after reset");

endmodule

bind scope_trace_pixel_byte_renderer_unit stpbr_checker u_stpbr_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_opcode     (req_opcode),
   .req_column     (req_column),
   .rsp_valid      (rsp_valid),
   .rsp_pixel_byte (rsp_pixel_byte)
);
`default_nettype wire
